[sv/spf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spf_pkg - shared types and constants of the SMS-SUBMIT PDU framer
// Opcodes, limits, coding octets, the configuration bundle and the queue
// record passed from the front end to the octet sequencer.
// ----------------------------------------------------------------------------
package spf_pkg;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_CENTRE = 2'd1;
  localparam logic [1:0] OP_DEST   = 2'd2;
  localparam logic [1:0] OP_TEXT   = 2'd3;

  localparam logic [4:0] MAX_ADDR_DIGITS = 5'd20;
  localparam logic [7:0] MAX_TEXT_UNITS  = 8'd160;
  // UCS2 length octet counts bytes, so it must stay below 256
  localparam logic [7:0] MAX_WIDE_UNITS  = 8'd127;

  localparam logic [7:0] DCS_GSM  = 8'h00;
  localparam logic [7:0] DCS_UCS2 = 8'h08;
  localparam logic [3:0] PAD_NIBBLE = 4'hF;

  localparam logic [2:0] REG_ADDRESS_TYPE      = 3'd0;
  localparam logic [2:0] REG_FIRST_OCTET       = 3'd1;
  localparam logic [2:0] REG_MESSAGE_REFERENCE = 3'd2;
  localparam logic [2:0] REG_PROTOCOL_ID       = 3'd3;
  localparam logic [2:0] REG_VALIDITY_PERIOD   = 3'd4;

  localparam logic [7:0] RST_ADDRESS_TYPE      = 8'h91;
  localparam logic [7:0] RST_FIRST_OCTET       = 8'h11;
  localparam logic [7:0] RST_MESSAGE_REFERENCE = 8'h00;
  localparam logic [7:0] RST_PROTOCOL_ID       = 8'h00;
  localparam logic [7:0] RST_VALIDITY_PERIOD   = 8'h81;

  localparam int REC_OCTETS = 5;

  typedef struct packed {
    logic [7:0] address_type;
    logic [7:0] first_octet;
    logic [7:0] message_reference;
    logic [7:0] protocol_id;
    logic [7:0] validity_period;
  } cfg_t;

  // Up to five octets produced by one item; last marks the final octet.
  typedef struct packed {
    logic [REC_OCTETS-1:0][7:0] octets;
    logic [2:0]                 count;
    logic                       last;
    logic                       error;
  } rec_t;

endpackage
`default_nettype wire

[sv/spf_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spf_front - item decoder and PDU state
// Checks each item against the current section, updates the framing state
// and builds the record of octets that the item produces.
// ----------------------------------------------------------------------------
module spf_front import spf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [4:0]  centre_digits,
  input  wire logic [4:0]  dest_digits,
  input  wire logic [7:0]  text_count,
  input  wire logic        wide_mode,
  input  wire logic [3:0]  digit,
  input  wire logic [15:0] text_unit,
  input  wire cfg_t        cfg,
  input  wire logic        q_full,
  output logic             push,
  output rec_t             rec
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_CENTRE = 3'd1;
  localparam logic [2:0] PH_DEST   = 3'd2;
  localparam logic [2:0] PH_TEXT   = 3'd3;

  logic [2:0]  phase, phase_next;
  logic [4:0]  digits_left, digits_left_next;
  logic [4:0]  dest_total, dest_total_next;
  logic [7:0]  text_left, text_left_next;
  logic [7:0]  text_total, text_total_next;
  logic        wide_flag, wide_flag_next;
  logic [3:0]  held_nibble, held_nibble_next;
  logic        nibble_valid, nibble_valid_next;
  logic [13:0] septet_queue, septet_queue_next;
  logic [2:0]  queue_bits, queue_bits_next;

  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (rec.count != 3'd0);

  always_comb begin
    logic [2:0]  n;
    logic        dfinal;
    logic        tfinal;
    logic        bad_start;
    logic [5:0]  half;
    logic [13:0] q;
    logic [3:0]  qb;

    phase_next        = phase;
    digits_left_next  = digits_left;
    dest_total_next   = dest_total;
    text_left_next    = text_left;
    text_total_next   = text_total;
    wide_flag_next    = wide_flag;
    held_nibble_next  = held_nibble;
    nibble_valid_next = nibble_valid;
    septet_queue_next = septet_queue;
    queue_bits_next   = queue_bits;
    rec    = '0;
    n      = 3'd0;
    dfinal = (digits_left <= 5'd1);
    tfinal = (text_left == 8'd1);
    half   = ({1'b0, centre_digits} + 6'd1) >> 1;
    q      = septet_queue | (14'({7'b0, text_unit[6:0]}) << queue_bits);
    qb     = {1'b0, queue_bits} + 4'd7;
    bad_start = (phase != PH_IDLE) ||
                (centre_digits == 5'd0) || (centre_digits > MAX_ADDR_DIGITS) ||
                (dest_digits == 5'd0) || (dest_digits > MAX_ADDR_DIGITS) ||
                (text_count > MAX_TEXT_UNITS) ||
                (wide_mode && (text_count > MAX_WIDE_UNITS));

    case (opcode)
      OP_START: begin
        if (!bad_start) begin
          phase_next        = PH_CENTRE;
          digits_left_next  = centre_digits;
          dest_total_next   = dest_digits;
          text_total_next   = text_count;
          text_left_next    = text_count;
          wide_flag_next    = wide_mode;
          held_nibble_next  = 4'd0;
          nibble_valid_next = 1'b0;
          septet_queue_next = '0;
          queue_bits_next   = 3'd0;
          rec.octets[0] = {2'b0, half} + 8'd1;
          rec.octets[1] = cfg.address_type;
          n = 3'd2;
        end
      end
      OP_CENTRE, OP_DEST: begin
        if ((opcode == OP_CENTRE && phase == PH_CENTRE) ||
            (opcode == OP_DEST && phase == PH_DEST)) begin
          // digit pair: first digit in the low nibble
          if (nibble_valid) begin
            rec.octets[n] = {digit, held_nibble};
            n = n + 3'd1;
            nibble_valid_next = 1'b0;
            held_nibble_next  = 4'd0;
          end else if (dfinal) begin
            rec.octets[n] = {PAD_NIBBLE, digit};
            n = n + 3'd1;
          end else begin
            held_nibble_next  = digit;
            nibble_valid_next = 1'b1;
          end
          digits_left_next = digits_left - 5'd1;
          if (dfinal) begin
            if (opcode == OP_CENTRE) begin
              rec.octets[n]          = cfg.first_octet;
              rec.octets[n + 3'd1]   = cfg.message_reference;
              rec.octets[n + 3'd2]   = {3'b0, dest_total};
              rec.octets[n + 3'd3]   = cfg.address_type;
              n = n + 3'd4;
              phase_next       = PH_DEST;
              digits_left_next = dest_total;
            end else begin
              rec.octets[n]        = cfg.protocol_id;
              rec.octets[n + 3'd1] = wide_flag ? DCS_UCS2 : DCS_GSM;
              rec.octets[n + 3'd2] = cfg.validity_period;
              rec.octets[n + 3'd3] = wide_flag ? {text_total[6:0], 1'b0} : text_total;
              n = n + 3'd4;
              if (text_total == 8'd0) begin
                rec.last          = 1'b1;
                phase_next        = PH_IDLE;
                digits_left_next  = 5'd0;
                dest_total_next   = 5'd0;
                text_left_next    = 8'd0;
                text_total_next   = 8'd0;
                wide_flag_next    = 1'b0;
                held_nibble_next  = 4'd0;
                nibble_valid_next = 1'b0;
                septet_queue_next = '0;
                queue_bits_next   = 3'd0;
              end else begin
                phase_next = PH_TEXT;
              end
            end
          end
        end
      end
      OP_TEXT: begin
        if (phase == PH_TEXT && text_left != 8'd0) begin
          text_left_next = text_left - 8'd1;
          rec.last = tfinal;
          if (wide_flag) begin
            rec.octets[0] = text_unit[15:8];
            rec.octets[1] = text_unit[7:0];
            n = 3'd2;
          end else begin
            if (qb >= 4'd8) begin
              rec.octets[n] = q[7:0];
              n  = n + 3'd1;
              q  = q >> 8;
              qb = qb - 4'd8;
            end
            // flush the partial octet after the final septet
            if (tfinal && qb != 4'd0) begin
              rec.octets[n] = q[7:0];
              n = n + 3'd1;
            end
            septet_queue_next = q;
            queue_bits_next   = qb[2:0];
          end
          if (tfinal) begin
            phase_next        = PH_IDLE;
            digits_left_next  = 5'd0;
            dest_total_next   = 5'd0;
            text_left_next    = 8'd0;
            text_total_next   = 8'd0;
            wide_flag_next    = 1'b0;
            held_nibble_next  = 4'd0;
            nibble_valid_next = 1'b0;
            septet_queue_next = '0;
            queue_bits_next   = 3'd0;
          end
        end
      end
      default: begin
      end
    endcase

    // out-of-order item or bad start: one error octet, back to idle
    if ((opcode == OP_START && bad_start) ||
        (opcode == OP_CENTRE && phase != PH_CENTRE) ||
        (opcode == OP_DEST && phase != PH_DEST) ||
        (opcode == OP_TEXT && (phase != PH_TEXT || text_left == 8'd0))) begin
      rec               = '0;
      rec.last          = 1'b1;
      rec.error         = 1'b1;
      n                 = 3'd1;
      phase_next        = PH_IDLE;
      digits_left_next  = 5'd0;
      dest_total_next   = 5'd0;
      text_left_next    = 8'd0;
      text_total_next   = 8'd0;
      wide_flag_next    = 1'b0;
      held_nibble_next  = 4'd0;
      nibble_valid_next = 1'b0;
      septet_queue_next = '0;
      queue_bits_next   = 3'd0;
    end
    rec.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      digits_left  <= 5'd0;
      dest_total   <= 5'd0;
      text_left    <= 8'd0;
      text_total   <= 8'd0;
      wide_flag    <= 1'b0;
      held_nibble  <= 4'd0;
      nibble_valid <= 1'b0;
      septet_queue <= '0;
      queue_bits   <= 3'd0;
    end else if (accept) begin
      phase        <= phase_next;
      digits_left  <= digits_left_next;
      dest_total   <= dest_total_next;
      text_left    <= text_left_next;
      text_total   <= text_total_next;
      wide_flag    <= wide_flag_next;
      held_nibble  <= held_nibble_next;
      nibble_valid <= nibble_valid_next;
      septet_queue <= septet_queue_next;
      queue_bits   <= queue_bits_next;
    end
  end

endmodule
`default_nettype wire

[sv/spf_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spf_fifo - two-entry record queue
// Decouples the item decoder from the octet sequencer.
// ----------------------------------------------------------------------------
module spf_fifo import spf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire rec_t wr_rec,
  input  wire logic pop,
  output rec_t      rd_rec,
  output logic      full,
  output logic      empty
);

  rec_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full   = (count == 2'd2);
  assign empty  = (count == 2'd0);
  assign rd_rec = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

[sv/spf_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spf_back - octet sequencer
// Walks the head record one octet a cycle into the output register when not stalled.
// ----------------------------------------------------------------------------
module spf_back import spf_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire rec_t       head,
  input  wire logic       q_empty,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_octet,
  output logic            out_last,
  output logic            out_error
);

  logic [2:0] idx;
  logic       load;
  logic       at_end;

  assign load   = !out_valid || out_ready;
  assign at_end = (idx == head.count - 3'd1);
  assign pop    = load && !q_empty && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 3'd0;
    end else if (load) begin
      out_valid <= !q_empty;
      if (!q_empty) begin
        idx <= at_end ? 3'd0 : idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      out_octet <= head.octets[idx];
      out_last  <= head.last && at_end;
      out_error <= head.error;
    end
  end

endmodule
`default_nettype wire

[sv/sms_submit_pdu_framer_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sms_submit_pdu_framer_unit - SMS-SUBMIT PDU octet framer
// Items in on the s_ stream (start, centre digits, destination digits, text
// units, with the opcode on s_tuser); PDU octets out on the m_ stream with
// m_tlast on the final octet and m_tuser flagging an error octet.
// Header octets (address type, PDU type, message reference, protocol id,
// validity period) come from the APB registers, which the user must write
// only while idle; the block does not enforce this. Each accepted item's
// octets pass through the record queue and then the output register. The
// decoder takes an item every cycle while its two-entry record queue has
// room; the output sequencer sends one octet a cycle while m_tready is high.
// An item that produces no octet (first of a digit pair, or a septet that
// does not yet fill an octet) only updates the state.
// When m_tready is low the output register holds, the queue fills and then
// s_tready drops. Reset clears the state to idle, empties the queue and
// loads the register defaults.
// ----------------------------------------------------------------------------
module sms_submit_pdu_framer_unit import spf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [4:0] centre_digits, [9:5] dest_digits, [17:10] text_count,
  // [18] wide_mode, [22:19] digit, [38:23] text_unit, [39] zero
  input  wire logic [39:0] s_tdata,
  // [1:0] opcode
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [7:0] octet
  output logic [7:0]       m_tdata,
  output logic             m_tlast,
  // [0] error
  output logic             m_tuser,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t       cfg;
  rec_t       wr_rec;
  rec_t       head;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_empty;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.address_type      <= RST_ADDRESS_TYPE;
      cfg.first_octet       <= RST_FIRST_OCTET;
      cfg.message_reference <= RST_MESSAGE_REFERENCE;
      cfg.protocol_id       <= RST_PROTOCOL_ID;
      cfg.validity_period   <= RST_VALIDITY_PERIOD;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_ADDRESS_TYPE:      cfg.address_type      <= pwdata[7:0];
        REG_FIRST_OCTET:       cfg.first_octet       <= pwdata[7:0];
        REG_MESSAGE_REFERENCE: cfg.message_reference <= pwdata[7:0];
        REG_PROTOCOL_ID:       cfg.protocol_id       <= pwdata[7:0];
        REG_VALIDITY_PERIOD:   cfg.validity_period   <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ADDRESS_TYPE:      prdata = {24'd0, cfg.address_type};
      REG_FIRST_OCTET:       prdata = {24'd0, cfg.first_octet};
      REG_MESSAGE_REFERENCE: prdata = {24'd0, cfg.message_reference};
      REG_PROTOCOL_ID:       prdata = {24'd0, cfg.protocol_id};
      REG_VALIDITY_PERIOD:   prdata = {24'd0, cfg.validity_period};
      default:               prdata = 32'd0;
    endcase
  end

  spf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .opcode        (s_tuser),
    .centre_digits (s_tdata[4:0]),
    .dest_digits   (s_tdata[9:5]),
    .text_count    (s_tdata[17:10]),
    .wide_mode     (s_tdata[18]),
    .digit         (s_tdata[22:19]),
    .text_unit     (s_tdata[38:23]),
    .cfg           (cfg),
    .q_full        (q_full),
    .push          (push),
    .rec           (wr_rec)
  );

  spf_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_rec (wr_rec),
    .pop    (pop),
    .rd_rec (head),
    .full   (q_full),
    .empty  (q_empty)
  );

  spf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_octet (m_tdata),
    .out_last  (m_tlast),
    .out_error (m_tuser)
  );

endmodule
`default_nettype wire

[sv/spf_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spf_checker - port-level checks of the PDU framer
// Error octets, stalled output and the configuration port.
// ----------------------------------------------------------------------------
module spf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast,
  input wire logic       m_tuser,
  input wire logic       pready
);

  // an error octet ends the message
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("error octet without tlast");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 8'd0)
    else $error("error octet not zero");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled octet changed");

  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready low");

endmodule

bind sms_submit_pdu_framer_unit spf_checker u_spf_checker (.*);
`default_nettype wire
